// ----- hdl/icmp_echo_pkg.sv -----
package icmp_echo_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 112;

  localparam logic [CountW-1:0] CountCap     = CountW'(4);
  localparam logic [CountW-1:0] CountBodyMin = CountW'(2);
  localparam logic [CountW-1:0] CountMinLen  = CountW'(3);
  localparam logic [ByteW-1:0]  EchoRequest  = ByteW'(8);
  localparam logic [ByteW-1:0]  EchoReply    = ByteW'(0);
  localparam logic [ByteW-1:0]  CodeZero     = ByteW'(0);
  localparam logic [WordW-1:0]  SumOnes      = 16'hFFFF;

  typedef enum logic [1:0] {
    VERDICT_REPLY = 2'd0,
    VERDICT_PASS  = 2'd1,
    VERDICT_DROP  = 2'd2
  } verdict_e;

  // one's-complement add with end-around carry
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + WordW'(s[WordW]);
  endfunction

endpackage

// ----- hdl/icmp_echo_responder.sv -----
// ICMP echo responder. Takes an ICMP message one 16-bit big-endian word per
// cycle on the slave stream; tlast marks the final word and tuser flags an odd
// final byte. IPv4 addresses, TOS and ingress port are sampled with the first
// word. On the last word one result word is issued: tuser carries the verdict
// (0 reply, 1 pass to host, 2 drop). For a valid echo request the result holds
// the reply header (type 0, same code), the recomputed checksum, swapped
// addresses, TOS and port; otherwise the data fields are zero. An input
// register feeds three end-around-carry adders and the verdict logic into a
// result register, so a new word is taken each cycle unless the result
// register is held by downstream backpressure. The last word passes through
// the input register and then the result register before its result appears.
module icmp_echo_responder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // data_word[15:0], ip_source[47:16], ip_dest[79:48],
  // service_type[87:80], ingress_port[95:88]
  input  logic [icmp_echo_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  // odd_byte[0]
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // reply_header_word[15:0], reply_checksum[31:16], reply_dest[63:32],
  // reply_source[95:64], reply_service_type[103:96], egress_port[111:104]
  output logic [icmp_echo_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // verdict[1:0]
  output logic [1:0]                           m_axis_tuser_o
);

  localparam int unsigned WordW  = icmp_echo_pkg::WordW;
  localparam int unsigned AddrW  = icmp_echo_pkg::AddrW;
  localparam int unsigned ByteW  = icmp_echo_pkg::ByteW;
  localparam int unsigned CountW = icmp_echo_pkg::CountW;

  // input register
  logic                                in_valid_q;
  logic [icmp_echo_pkg::InDataW-1:0]   in_data_q;
  logic                                in_last_q;
  logic                                in_odd_q;

  // message state
  logic [WordW-1:0]  sum_all_q, sum_all_d;
  logic [WordW-1:0]  sum_body_q, sum_body_d;
  logic [CountW-1:0] count_q, count_d;
  logic [WordW-1:0]  first_q;
  logic [AddrW-1:0]  src_q, dst_q;
  logic [ByteW-1:0]  tos_q, port_q;

  // result register
  logic                                out_valid_q;
  logic [icmp_echo_pkg::OutDataW-1:0]  out_data_q, out_data_d;
  icmp_echo_pkg::verdict_e             verdict_q, verdict_d;

  logic advance;
  logic [WordW-1:0] word;
  logic first_now;
  logic [WordW-1:0] first_w;
  logic [AddrW-1:0] src_w, dst_w;
  logic [ByteW-1:0] tos_w, port_w, msg_type, msg_code;
  logic [WordW-1:0] total, body, csum_raw, csum;
  logic short_msg;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    word = in_data_q[WordW-1:0];
    if (in_last_q && in_odd_q) begin
      word[ByteW-1:0] = '0;
    end
    first_now = (count_q == '0);
    first_w   = first_now ? word : first_q;
    src_w     = first_now ? in_data_q[WordW +: AddrW] : src_q;
    dst_w     = first_now ? in_data_q[WordW+AddrW +: AddrW] : dst_q;
    tos_w     = first_now ? in_data_q[WordW+2*AddrW +: ByteW] : tos_q;
    port_w    = first_now ? in_data_q[WordW+2*AddrW+ByteW +: ByteW] : port_q;
    msg_type  = first_w[WordW-1:ByteW];
    msg_code  = first_w[ByteW-1:0];

    total = icmp_echo_pkg::oc_add(sum_all_q, word);
    body  = (count_q >= icmp_echo_pkg::CountBodyMin) ?
            icmp_echo_pkg::oc_add(sum_body_q, word) : sum_body_q;

    if (in_last_q) begin
      sum_all_d  = '0;
      sum_body_d = '0;
      count_d    = '0;
    end else begin
      sum_all_d  = total;
      sum_body_d = body;
      count_d    = (count_q < icmp_echo_pkg::CountCap) ? count_q + CountW'(1) : count_q;
    end

    short_msg = (count_q < icmp_echo_pkg::CountMinLen) ||
                ((count_q == icmp_echo_pkg::CountMinLen) && in_odd_q);

    if (short_msg) begin
      verdict_d = icmp_echo_pkg::VERDICT_DROP;
    end else if (msg_type != icmp_echo_pkg::EchoRequest) begin
      verdict_d = icmp_echo_pkg::VERDICT_PASS;
    end else if (msg_code != icmp_echo_pkg::CodeZero) begin
      verdict_d = icmp_echo_pkg::VERDICT_DROP;
    end else if (total != icmp_echo_pkg::SumOnes) begin
      verdict_d = icmp_echo_pkg::VERDICT_DROP;
    end else begin
      verdict_d = icmp_echo_pkg::VERDICT_REPLY;
    end

    csum_raw = icmp_echo_pkg::oc_add(body, {{(WordW-ByteW){1'b0}}, msg_code});
    csum     = (csum_raw == icmp_echo_pkg::SumOnes) ? csum_raw : ~csum_raw;

    if (verdict_d == icmp_echo_pkg::VERDICT_REPLY) begin
      out_data_d = {port_w, tos_w, dst_w, src_w, csum,
                    icmp_echo_pkg::EchoReply, msg_code};
    end else begin
      out_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
      in_odd_q  <= s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_all_q  <= '0;
      sum_body_q <= '0;
      count_q    <= '0;
      first_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      tos_q      <= '0;
      port_q     <= '0;
    end else if (advance) begin
      sum_all_q  <= sum_all_d;
      sum_body_q <= sum_body_d;
      count_q    <= count_d;
      first_q    <= first_w;
      src_q      <= src_w;
      dst_q      <= dst_w;
      tos_q      <= tos_w;
      port_q     <= port_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_last_q;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= out_data_d;
      verdict_q  <= verdict_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = verdict_q;

endmodule

// ----- tb/icmp_echo_checker.sv -----
`timescale 1ns / 100ps

module icmp_echo_checker
  import icmp_echo_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [1:0]          m_tuser_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    verdict_e         verdict;
    logic [WordW-1:0] header;
    logic [WordW-1:0] csum;
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] source;
    logic [ByteW-1:0] tos;
    logic [ByteW-1:0] port;
  } echo_result_t;

  echo_result_t reply_q[$];
  echo_result_t want;
  int           errors = 0;
  int           pending = 0;

  logic [WordW-1:0]  sum_all_q;
  logic [WordW-1:0]  sum_body_q;
  logic [CountW-1:0] seen_q;
  logic [WordW-1:0]  hdr_word_q;
  logic [AddrW-1:0]  req_src_q;
  logic [AddrW-1:0]  req_dst_q;
  logic [ByteW-1:0]  req_tos_q;
  logic [ByteW-1:0]  req_port_q;

  assign fail_count_o = errors;
  assign pending_o    = pending;

  function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %h exp %h", name, got, exp_val));
    end
  endtask

  task automatic absorb_word(input logic [InDataW-1:0] data, input logic last,
                             input logic odd);
    logic [WordW-1:0]  w;
    logic [WordW-1:0]  total;
    logic [WordW-1:0]  body;
    logic [CountW-1:0] prior;
    logic [ByteW-1:0]  kind;
    logic [ByteW-1:0]  code;
    logic              is_short;
    echo_result_t      r;
    w = data[15:0];
    if (last && odd) begin
      w[7:0] = 8'h00;
    end
    prior = seen_q;
    if (prior == '0) begin
      hdr_word_q = w;
      req_src_q  = data[47:16];
      req_dst_q  = data[79:48];
      req_tos_q  = data[87:80];
      req_port_q = data[95:88];
    end
    total = ones_add(sum_all_q, w);
    body  = (prior >= CountBodyMin) ? ones_add(sum_body_q, w) : sum_body_q;
    if (!last) begin
      sum_all_q  = total;
      sum_body_q = body;
      if (prior < CountCap) begin
        seen_q = prior + CountW'(1);
      end
    end else begin
      sum_all_q  = '0;
      sum_body_q = '0;
      seen_q     = '0;
      is_short = (prior < CountMinLen) || (prior == CountMinLen && odd);
      kind = hdr_word_q[15:8];
      code = hdr_word_q[7:0];
      r = '0;
      if (is_short) begin
        r.verdict = VERDICT_DROP;
      end else if (kind != EchoRequest) begin
        r.verdict = VERDICT_PASS;
      end else if (code != CodeZero) begin
        r.verdict = VERDICT_DROP;
      end else if (total != SumOnes) begin
        r.verdict = VERDICT_DROP;
      end else begin
        r.verdict = VERDICT_REPLY;
        r.header  = {EchoReply, code};
        r.csum    = ones_add(body, {8'h00, code});
        if (r.csum != SumOnes) begin
          r.csum = ~r.csum;
        end
        r.dest   = req_src_q;
        r.source = req_dst_q;
        r.tos    = req_tos_q;
        r.port   = req_port_q;
      end
      reply_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sum_all_q  = '0;
      sum_body_q = '0;
      seen_q     = '0;
      hdr_word_q = '0;
      req_src_q  = '0;
      req_dst_q  = '0;
      req_tos_q  = '0;
      req_port_q = '0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = reply_q.pop_front();
          check_field("verdict", 32'(m_tuser_i), 32'(want.verdict));
          check_field("header", 32'(m_tdata_i[15:0]), 32'(want.header));
          check_field("checksum", 32'(m_tdata_i[31:16]), 32'(want.csum));
          check_field("dest", m_tdata_i[63:32], want.dest);
          check_field("source", m_tdata_i[95:64], want.source);
          check_field("tos", 32'(m_tdata_i[103:96]), 32'(want.tos));
          check_field("port", 32'(m_tdata_i[111:104]), 32'(want.port));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_word(s_tdata_i, s_tlast_i, s_tuser_i);
      end
    end
    pending = reply_q.size();
  end

endmodule

// ----- tb/icmp_echo_responder_tb.sv -----
`timescale 1ns / 100ps

module icmp_echo_responder_tb;
  import icmp_echo_pkg::*;

  localparam int WordTarget = 1250;
  localparam int CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int fail_count;
  int pending;
  int cycles = 0;
  int words_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;

  logic [WordW-1:0] msg_q[$];

  icmp_echo_responder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  icmp_echo_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [WordW-1:0] fold_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  // checksum word makes the full one's-complement sum 0xFFFF
  task automatic seal_checksum(input bit odd);
    logic [WordW-1:0] s;
    logic [WordW-1:0] w;
    s = '0;
    for (int i = 0; i < msg_q.size(); i++) begin
      w = msg_q[i];
      if (odd && i == msg_q.size() - 1) begin
        w[7:0] = 8'h00;
      end
      if (i != 1) begin
        s = fold_add(s, w);
      end
    end
    msg_q[1] = ~s;
  endtask

  task automatic build_message(input int len, input logic [WordW-1:0] hdr);
    msg_q = {};
    msg_q.push_back(hdr);
    for (int i = 1; i < len; i++) begin
      msg_q.push_back(WordW'($urandom));
    end
  endtask

  task automatic send_word(input logic [WordW-1:0] w, input bit last, input bit odd,
                           input logic [AddrW-1:0] src, input logic [AddrW-1:0] dst,
                           input logic [ByteW-1:0] tos, input logic [ByteW-1:0] port);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {port, tos, dst, src, w};
    s_axis_tlast  <= last;
    s_axis_tuser  <= odd;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_message(input bit odd, input logic [AddrW-1:0] src,
                              input logic [AddrW-1:0] dst, input logic [ByteW-1:0] tos,
                              input logic [ByteW-1:0] port);
    bit last;
    for (int i = 0; i < msg_q.size(); i++) begin
      last = (i == msg_q.size() - 1);
      if (i == 0) begin
        send_word(msg_q[i], last, last ? odd : 1'($urandom), src, dst, tos, port);
      end else begin
        send_word(msg_q[i], last, last ? odd : 1'($urandom), $urandom, $urandom,
                  8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic random_message();
    int pick;
    int len;
    bit odd;
    logic [ByteW-1:0] kind;
    logic [ByteW-1:0] code;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(4, 10);
    odd  = 1'($urandom);
    kind = EchoRequest;
    code = CodeZero;
    if (pick >= 95) begin
      len = $urandom_range(1, 4);
    end else if (pick >= 87) begin
      do kind = 8'($urandom); while (kind == EchoRequest);
      code = 8'($urandom);
    end else if (pick >= 80) begin
      code = 8'($urandom_range(1, 255));
    end
    build_message(len, {kind, code});
    if (pick >= 68 && pick < 72) begin
      msg_q[0] = WordW'($urandom);
    end else if (len >= 2) begin
      seal_checksum(odd);
      if (pick >= 72 && pick < 80) begin
        msg_q[1] = msg_q[1] ^ WordW'($urandom_range(1, 65535));
      end
    end
    send_message(odd, $urandom, $urandom, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short messages: one, two and three words
    for (int len = 1; len <= 3; len++) begin
      build_message(len, {EchoRequest, CodeZero});
      if (len >= 2) begin
        seal_checksum(1'b0);
      end
      send_message(len == 1, '1, '1, '1, '1);
    end
    // seven bytes: short even with a good checksum
    build_message(4, {EchoRequest, CodeZero});
    seal_checksum(1'b1);
    send_message(1'b1, 32'h0A000001, 32'hC0A80101, 8'h10, 8'h03);
    // body sums to 0xFFFF, checksum kept
    msg_q = {{EchoRequest, CodeZero}, 16'h0000, 16'hFFFF, 16'h0000};
    seal_checksum(1'b0);
    send_message(1'b0, '1, '1, '1, '1);
    // all-zero payload and sideband
    msg_q = {{EchoRequest, CodeZero}, 16'h0000, 16'h0000, 16'h0000};
    seal_checksum(1'b0);
    send_message(1'b0, '0, '0, '0, '0);
    // echo reply type goes to host
    build_message(4, {EchoReply, CodeZero});
    seal_checksum(1'b0);
    send_message(1'b0, 32'h12345678, 32'h9ABCDEF0, 8'hB8, 8'h7F);
    // bad code
    build_message(4, {EchoRequest, 8'hFF});
    seal_checksum(1'b0);
    send_message(1'b0, 32'h80000000, 32'h00000001, 8'h01, 8'h80);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      while (words_sent < 26 + WordTarget * (phase + 1) / 4) begin
        random_message();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
